/* rtl/lpt_pkg.sv */
// Package with the types and constants shared by the printer handshake block.
package lpt_pkg;

  localparam int unsigned CharW    = 7;
  localparam int unsigned HitW     = 8;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_NO_HS   = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_HIT_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_TICKS = 2'd2;

  localparam logic [HitW-1:0]  HIT_COUNT_RST   = 8'd10;
  localparam logic [WaitW-1:0] TIMEOUT_RST     = 16'd10000;
  localparam logic [WaitW-1:0] RESET_TICKS_RST = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_READY = 3'd1,
    PH_ACK   = 3'd2,
    PH_NAK   = 3'd3,
    PH_RESET = 3'd4
  } phase_e;

  typedef struct packed {
    logic [HitW-1:0]  hit_count;
    logic [WaitW-1:0] timeout_samples;
    logic [WaitW-1:0] reset_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CharW-1:0] data_out;
    logic             strobe_out;
    logic             init_out;
    logic             in_progress;
    logic             done_res;
    logic [1:0]       status;
  } result_t;

endpackage

/* rtl/lpt_in_if.sv */
// Input channel interface: one sample tick with an optional operation request.
interface lpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] char_code;
  logic       busy_line;
  logic       ack_line;

  modport source (output valid, opcode, char_code, busy_line, ack_line, input ready);
  modport sink (input valid, opcode, char_code, busy_line, ack_line, output ready);
endinterface

/* rtl/lpt_out_if.sv */
// Output channel interface: the line and status picture after one tick.
interface lpt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] data_out;
  logic       strobe_out;
  logic       init_out;
  logic       in_progress;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, data_out, strobe_out, init_out, in_progress, done_res,
                  status, input ready);
  modport sink (input valid, data_out, strobe_out, init_out, in_progress, done_res,
                status, output ready);
endinterface

/* rtl/lpt_cfg_regs.sv */
// Configuration register file for the printer handshake block.
module lpt_cfg_regs
  import lpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIT_COUNT:   cfg_d.hit_count       = cfg_data_i[HitW-1:0];
        CFG_TIMEOUT:     cfg_d.timeout_samples = cfg_data_i[WaitW-1:0];
        CFG_RESET_TICKS: cfg_d.reset_ticks     = cfg_data_i[WaitW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_count       <= HIT_COUNT_RST;
      cfg_q.timeout_samples <= TIMEOUT_RST;
      cfg_q.reset_ticks     <= RESET_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/lpt_fsm.sv */
// Handshake sequencer: phase, qualify counters and line registers, one tick per item.
module lpt_fsm
  import lpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       opcode_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             busy_line_i,
  input  logic             ack_line_i,
  input  cfg_t             cfg_i,
  output result_t          result_o
);

  phase_e           phase_q, phase_d;
  logic [HitW-1:0]  hit_q, hit_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic             pend_q, pend_d;
  logic [CharW-1:0] data_q, data_d;
  logic [CharW-1:0] hold_q, hold_d;
  logic             strobe_q, strobe_d;
  logic             init_q, init_d;

  logic [HitW-1:0]  need;
  logic [WaitW-1:0] limit;
  logic [WaitW-1:0] rst_limit;
  logic             cond;
  logic [HitW-1:0]  hit_inc;
  logic [WaitW-1:0] wait_inc;
  logic             wait_ok;
  logic             wait_fail;
  logic             started;
  logic             start_reset;
  logic             done;
  logic [1:0]       st;

  assign need      = (cfg_i.hit_count == '0) ? HitW'(1) : cfg_i.hit_count;
  assign limit     = (cfg_i.timeout_samples == '0) ? WaitW'(1) : cfg_i.timeout_samples;
  assign rst_limit = (cfg_i.reset_ticks == '0) ? WaitW'(1) : cfg_i.reset_ticks;

  always_comb begin
    phase_d  = phase_q;
    hit_d    = hit_q;
    wait_d   = wait_q;
    pend_d   = pend_q;
    data_d   = data_q;
    hold_d   = hold_q;
    strobe_d = strobe_q;
    init_d   = init_q;
    done     = 1'b0;
    st       = ST_READY;
    started     = 1'b0;
    start_reset = 1'b0;

    // A send clears the wait counters and takes its first BUSY sample on
    // the same tick; a reset raises init and clears the wait counter on its first tick.
    if (phase_q == PH_IDLE) begin
      if (opcode_i == OP_SEND) begin
        hold_d  = char_code_i;
        phase_d = PH_READY;
        started = 1'b1;
      end else if (opcode_i == OP_RESET) begin
        init_d      = 1'b1;
        wait_d      = '0;
        phase_d     = PH_RESET;
        start_reset = 1'b1;
      end
    end

    case (phase_d)
      PH_ACK:  cond = ack_line_i;
      PH_NAK:  cond = !ack_line_i;
      default: cond = busy_line_i;
    endcase

    hit_inc = started ? '0 : hit_q;
    if (cond) begin
      hit_inc = (hit_inc != {HitW{1'b1}}) ? hit_inc + HitW'(1) : hit_inc;
    end else begin
      hit_inc = '0;
    end
    wait_inc = started ? '0 : wait_q;
    wait_inc = (wait_inc != {WaitW{1'b1}}) ? wait_inc + WaitW'(1) : wait_inc;
    wait_ok   = hit_inc >= need;
    wait_fail = wait_inc >= limit;

    if (!start_reset) begin
      case (phase_d)
        PH_IDLE: begin
        end
        PH_READY: begin
          hit_d  = hit_inc;
          wait_d = wait_inc;
          if (wait_ok) begin
            hit_d  = '0;
            wait_d = '0;
            if (pend_q) begin
              phase_d = PH_NAK;
            end else begin
              data_d  = hold_d;
              phase_d = PH_ACK;
            end
          end else if (wait_fail) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            st      = ST_DEAD;
          end
        end
        PH_ACK: begin
          hit_d  = hit_inc;
          wait_d = wait_inc;
          if (wait_ok) begin
            strobe_d = 1'b1;
            pend_d   = 1'b1;
            hit_d    = '0;
            wait_d   = '0;
            phase_d  = PH_NAK;
          end else if (wait_fail) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            st      = ST_NO_HS;
          end
        end
        PH_NAK: begin
          hit_d  = hit_inc;
          wait_d = wait_inc;
          if (wait_ok) begin
            strobe_d = 1'b0;
            pend_d   = 1'b0;
            phase_d  = PH_IDLE;
            done     = 1'b1;
            st       = ST_READY;
          end else if (wait_fail) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            st      = ST_NO_HS;
          end
        end
        PH_RESET: begin
          wait_d = (wait_q != {WaitW{1'b1}}) ? wait_q + WaitW'(1) : wait_q;
          if (wait_d >= rst_limit) begin
            init_d   = 1'b0;
            strobe_d = 1'b0;
            pend_d   = 1'b0;
            phase_d  = PH_IDLE;
            done     = 1'b1;
            st       = ST_READY;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    result_o.data_out    = data_d;
    result_o.strobe_out  = strobe_d;
    result_o.init_out    = init_d;
    result_o.in_progress = (phase_d != PH_IDLE);
    result_o.done_res    = done;
    result_o.status      = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      hit_q    <= '0;
      wait_q   <= '0;
      pend_q   <= 1'b0;
      data_q   <= '0;
      hold_q   <= '0;
      strobe_q <= 1'b0;
      init_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hit_q    <= hit_d;
      wait_q   <= wait_d;
      pend_q   <= pend_d;
      data_q   <= data_d;
      hold_q   <= hold_d;
      strobe_q <= strobe_d;
      init_q   <= init_d;
    end
  end

`ifndef SYNTHESIS
  // Strobe is only raised together with the pending mark and dropped with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_q |-> pend_q)
    else $error("strobe asserted without a pending handshake");

  // Init is driven exactly while a printer reset is under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni) init_q == (phase_q == PH_RESET))
    else $error("init line out of step with reset phase");

  // A reset request taken while idle enters the reset phase with init up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (phase_q == PH_IDLE) && (opcode_i == OP_RESET)
    |=> (phase_q == PH_RESET) && init_q)
    else $error("reset request not started");

  // The sequencer only moves on an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(phase_q) && $stable(wait_q) && $stable(hit_q))
    else $error("sequencer state moved without an item");
`endif

endmodule

/* rtl/lpt_out_stage.sv */
// Output register that holds one result while the receiver stalls.
module lpt_out_stage
  import lpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  result_t   result_i,
  output logic      free_o,
  lpt_out_if.source out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.data_out    = res_q.data_out;
  assign out_o.strobe_out  = res_q.strobe_out;
  assign out_o.init_out    = res_q.init_out;
  assign out_o.in_progress = res_q.in_progress;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.status      = res_q.status;

endmodule

/* rtl/lpt_printer_handshake_core.sv */
// Top level of the host-side parallel printer handshake block.
//
// Usage: every item on in_i is one sample tick of the printer status lines
// (BUSY and ACK) and may also request a character send or a printer reset.
// For every accepted item exactly one item appears on out_o, carrying the
// data, strobe and init lines as they stand after that tick, whether an
// operation is still in progress, and a done flag with its status.
// Requests that arrive while an operation is in progress act as plain ticks.
// An accepted item's result is registered and shows on out_o in the next
// cycle. Throughput is one item per cycle while the receiver keeps up; the
// sequencer state update and result build form a single short combinational
// step into the output register. in_i.ready is high while the output
// register is empty or is being drained in the same cycle, so a stalled
// receiver holds the result and stops intake only once a result is waiting.
// Configuration (hit count, timeout, reset length) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Reset clears the sequencer to idle with all lines low and restores the
// configuration defaults; no clearing pass is needed.
module lpt_printer_handshake_core
  import lpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lpt_in_if.sink              in_i,
  lpt_out_if.source           out_o
);

  cfg_t    cfg;
  result_t result;
  logic    free;
  logic    accept;

  // An item is taken whenever the output register can take its result.
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  lpt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpt_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (in_i.opcode),
    .char_code_i (in_i.char_code),
    .busy_line_i (in_i.busy_line),
    .ack_line_i  (in_i.ack_line),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  lpt_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the parallel printer handshake block, with its scoreboard class.
module tb_top;
  import lpt_pkg::*;

  // Opcode value outside the defined set; the block treats it as a plain tick.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Longest random wait on either side of the handshake, in cycles.
  localparam int unsigned MaxGap = 19;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned IdleLimit = 1000;

  // Outcome of one sample taken by a line wait.
  typedef enum int {QUAL_PENDING, QUAL_MET, QUAL_TIMEOUT} qual_e;

  // The scoreboard carries its own copy of the sequencer and the configuration.
  // Each accepted tick advances that copy and queues the line picture that
  // the block has to show for it; each result item is checked against the
  // oldest picture in the queue.
  class lpt_scoreboard;
    result_t          line_picture_q[$];
    int unsigned      err_count;
    logic [HitW-1:0]  hit_need;
    logic [WaitW-1:0] wait_limit;
    logic [WaitW-1:0] init_len;
    phase_e           seq_phase;
    logic [HitW-1:0]  run_hits;
    logic [WaitW-1:0] run_samples;
    logic             hs_open;
    logic [CharW-1:0] data_lines;
    logic [CharW-1:0] char_queued;
    logic             strobe_line;
    logic             init_line;

    function new();
      err_count   = 0;
      hit_need    = HIT_COUNT_RST;
      wait_limit  = TIMEOUT_RST;
      init_len    = RESET_TICKS_RST;
      seq_phase   = PH_IDLE;
      run_hits    = '0;
      run_samples = '0;
      hs_open     = 1'b0;
      data_lines  = '0;
      char_queued = '0;
      strobe_line = 1'b0;
      init_line   = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_HIT_COUNT:   hit_need = value[HitW-1:0];
        CFG_TIMEOUT:     wait_limit = value;
        CFG_RESET_TICKS: init_len = value;
        default: ;
      endcase
    endfunction

    // One sample of a line wait. Both counters saturate; zero settings act as one.
    function qual_e sample_wait(bit cond);
      logic [HitW-1:0]  need;
      logic [WaitW-1:0] lim;
      need = (hit_need == '0) ? HitW'(1) : hit_need;
      lim  = (wait_limit == '0) ? WaitW'(1) : wait_limit;
      if (cond) begin
        if (run_hits != '1) run_hits++;
      end else begin
        run_hits = '0;
      end
      if (run_samples != '1) run_samples++;
      if (run_hits >= need) return QUAL_MET;
      if (run_samples >= lim) return QUAL_TIMEOUT;
      return QUAL_PENDING;
    endfunction

    function void start_wait(phase_e ph);
      seq_phase   = ph;
      run_hits    = '0;
      run_samples = '0;
    endfunction

    function void note_tick(logic [1:0] op, logic [CharW-1:0] ch, bit busy_ok, bit ack_hi);
      result_t          res;
      qual_e            q;
      logic [WaitW-1:0] lim;
      bit               done;
      logic [1:0]       st;
      bit               reset_begun;
      done        = 1'b0;
      st          = ST_READY;
      reset_begun = 1'b0;
      if (seq_phase == PH_IDLE) begin
        if (op == OP_SEND) begin
          char_queued = ch;
          start_wait(PH_READY);
        end else if (op == OP_RESET) begin
          init_line   = 1'b1;
          run_samples = '0;
          seq_phase   = PH_RESET;
          reset_begun = 1'b1;
        end
      end
      if (!reset_begun) begin
        case (seq_phase)
          PH_READY: begin
            q = sample_wait(busy_ok);
            if (q == QUAL_MET) begin
              if (hs_open) begin
                start_wait(PH_NAK);
              end else begin
                data_lines = char_queued;
                start_wait(PH_ACK);
              end
            end else if (q == QUAL_TIMEOUT) begin
              seq_phase = PH_IDLE;
              done      = 1'b1;
              st        = ST_DEAD;
            end
          end
          PH_ACK: begin
            q = sample_wait(ack_hi);
            if (q == QUAL_MET) begin
              strobe_line = 1'b1;
              hs_open     = 1'b1;
              start_wait(PH_NAK);
            end else if (q == QUAL_TIMEOUT) begin
              seq_phase = PH_IDLE;
              done      = 1'b1;
              st        = ST_NO_HS;
            end
          end
          PH_NAK: begin
            q = sample_wait(!ack_hi);
            if (q == QUAL_MET) begin
              strobe_line = 1'b0;
              hs_open     = 1'b0;
              seq_phase   = PH_IDLE;
              done        = 1'b1;
              st          = ST_READY;
            end else if (q == QUAL_TIMEOUT) begin
              seq_phase = PH_IDLE;
              done      = 1'b1;
              st        = ST_NO_HS;
            end
          end
          PH_RESET: begin
            lim = (init_len == '0) ? WaitW'(1) : init_len;
            if (run_samples != '1) run_samples++;
            if (run_samples >= lim) begin
              init_line   = 1'b0;
              strobe_line = 1'b0;
              hs_open     = 1'b0;
              seq_phase   = PH_IDLE;
              done        = 1'b1;
              st          = ST_READY;
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
      res.data_out    = data_lines;
      res.strobe_out  = strobe_line;
      res.init_out    = init_line;
      res.in_progress = (seq_phase != PH_IDLE);
      res.done_res    = done;
      res.status      = st;
      line_picture_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      err_count++;
      $display("%0t ns MISMATCH: %s", $time, msg);
    endtask

    task check_field(string name, logic [CharW-1:0] got, logic [CharW-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (line_picture_q.size() == 0) begin
        report_mismatch("result item arrived with nothing outstanding");
        return;
      end
      want = line_picture_q.pop_front();
      check_field("data_out", got.data_out, want.data_out);
      check_field("strobe_out", CharW'(got.strobe_out), CharW'(want.strobe_out));
      check_field("init_out", CharW'(got.init_out), CharW'(want.init_out));
      check_field("in_progress", CharW'(got.in_progress), CharW'(want.in_progress));
      check_field("done_res", CharW'(got.done_res), CharW'(want.done_res));
      check_field("status", CharW'(got.status), CharW'(want.status));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  lpt_in_if  in_ch ();
  lpt_out_if out_ch ();

  lpt_printer_handshake_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  lpt_scoreboard sb = new();

  // While either flag is set, neither side inserts wait cycles. The first one
  // toggles at random to give stretches of full rate; the second one is held
  // for the very long operations so they finish in reasonable time.
  bit          quiet_stretch = 1'b0;
  bit          force_quiet = 1'b0;
  int unsigned ticks_sent = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang detection: the run ends if no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver. For every item it draws a stall, holds ready low for that
  // many cycles, then takes the next result and hands it to the scoreboard.
  initial begin : result_sink
    int unsigned stall;
    result_t     got;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (quiet_stretch || force_quiet) ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.data_out    = out_ch.data_out;
      got.strobe_out  = out_ch.strobe_out;
      got.init_out    = out_ch.init_out;
      got.in_progress = out_ch.in_progress;
      got.done_res    = out_ch.done_res;
      got.status      = out_ch.status;
      sb.check_result(got);
    end
  end

  // Sends one tick. A random gap comes first, then valid is held until the
  // block takes the item; the scoreboard sees the item on that same edge.
  // Valid is left high so that back-to-back ticks need no extra cycle.
  task automatic push_tick(logic [1:0] op, logic [CharW-1:0] ch, bit busy_ok, bit ack_hi);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) quiet_stretch = !quiet_stretch;
    gap = (quiet_stretch || force_quiet) ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.char_code <= ch;
    in_ch.busy_line <= busy_ok;
    in_ch.ack_line  <= ack_hi;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_tick(op, ch, busy_ok, ack_hi);
    ticks_sent++;
  endtask

  // Keeps ticking until the sequencer is back in idle. The line that the
  // current wait looks at takes its qualifying value with the given odds in
  // percent; the other line is random. Now and then a request is mixed in,
  // which the block has to ignore while it is busy.
  task automatic follow_through(int unsigned pct);
    logic [1:0] op;
    bit         busy_v;
    bit         ack_v;
    bit         hit;
    while (sb.seq_phase != PH_IDLE) begin
      hit    = ($urandom_range(1, 100) <= pct);
      busy_v = 1'($urandom_range(0, 1));
      ack_v  = 1'($urandom_range(0, 1));
      case (sb.seq_phase)
        PH_READY: busy_v = hit;
        PH_ACK:   ack_v = hit;
        PH_NAK:   ack_v = !hit;
        default: ;
      endcase
      op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
      push_tick(op, 7'($urandom), busy_v, ack_v);
    end
  endtask

  // A send request whose start tick already counts as the first BUSY sample.
  task automatic drive_send(logic [CharW-1:0] ch, int unsigned pct);
    push_tick(OP_SEND, ch, $urandom_range(1, 100) <= pct, 1'($urandom_range(0, 1)));
    follow_through(pct);
  endtask

  task automatic drive_reset();
    push_tick(OP_RESET, 7'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    follow_through(100);
  endtask

  // Lowers valid and waits until every queued result has been checked.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.line_picture_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Brings the block to rest and writes all three registers, one per edge.
  task automatic apply_setting(int unsigned hits, int unsigned tmo, int unsigned rst_len);
    logic [CfgIdxW-1:0]  idx_list [3];
    logic [CfgDataW-1:0] values [3];
    idx_list = '{CFG_HIT_COUNT, CFG_TIMEOUT, CFG_RESET_TICKS};
    values   = '{CfgDataW'(hits), CfgDataW'(tmo), CfgDataW'(rst_len)};
    follow_through(100);
    drain_results();
    cfg_we <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_idx  <= idx_list[i];
      cfg_data <= values[i];
      @(posedge clk_i);
      sb.write_reg(idx_list[i], values[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic under one setting. Most of it is well-formed sends whose
  // lines mostly cooperate, so the data, strobe and release phases are all
  // reached. Where waits are short, some sends get lines that cooperate less
  // than half the time so that timeouts show up too. The rest is printer resets and
  // bursts of fully random ticks.
  task automatic run_phase(int unsigned hits, int unsigned tmo, int unsigned rst_len,
                           int unsigned budget);
    int unsigned first_tick;
    int unsigned kind;
    int unsigned pct;
    int unsigned burst;
    apply_setting(hits, tmo, rst_len);
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < budget) begin
      kind = $urandom_range(0, 99);
      pct  = (tmo <= 64 && $urandom_range(0, 4) == 0) ? 40 : 90;
      if (kind < 60) begin
        drive_send(7'($urandom), pct);
      end else if (kind < 72) begin
        drive_reset();
      end else begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          push_tick(2'($urandom_range(0, 3)), 7'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_HIT_COUNT;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_TICK;
    in_ch.char_code <= '0;
    in_ch.busy_line <= 1'b0;
    in_ch.ack_line  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: one qualifying sample per wait and two samples before
    // a timeout, so every outcome takes only a few ticks.
    apply_setting(1, 2, 2);
    // The spare opcode and a plain tick must leave everything at rest.
    push_tick(OP_SPARE, 7'h7f, 1'b1, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b0, 1'b0);
    // Clean send of the top character code; the requests that arrive during
    // it are ignored.
    push_tick(OP_SEND, 7'h7f, 1'b1, 1'b0);
    push_tick(OP_RESET, 7'h00, 1'b0, 1'b1);
    push_tick(OP_SEND, 7'h55, 1'b1, 1'b0);
    // BUSY never goes inactive: the printer is reported dead.
    push_tick(OP_SEND, 7'h00, 1'b0, 1'b0);
    push_tick(OP_TICK, 7'h00, 1'b0, 1'b1);
    // ACK never rises after the data is driven: no handshake.
    push_tick(OP_SEND, 7'h2a, 1'b1, 1'b0);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b0);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b0);
    // ACK stays high after strobe: no handshake, with strobe still up.
    push_tick(OP_SEND, 7'h15, 1'b1, 1'b0);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b1);
    // The open handshake makes the next send skip the data phase, so the
    // data lines keep the previous character.
    push_tick(OP_SEND, 7'h6a, 1'b1, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b0);
    // Leave a handshake open again, then a printer reset has to drop strobe.
    push_tick(OP_SEND, 7'h01, 1'b1, 1'b0);
    push_tick(OP_TICK, 7'h00, 1'b1, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b0, 1'b1);
    push_tick(OP_TICK, 7'h00, 1'b0, 1'b1);
    push_tick(OP_RESET, 7'h00, 1'b1, 1'b1);
    push_tick(OP_SEND, 7'h7f, 1'b1, 1'b1);

    // Random part over several settings: all-zero registers, which act as
    // one, ordinary short waits, a hit count above the timeout so every
    // wait fails, the single-sample minimum, and the default hit count and
    // timeout with a short reset.
    run_phase(0, 0, 0, 120);
    run_phase(3, 12, 5, 250);
    run_phase(2, 40, 17, 250);
    run_phase(5, 3, 4, 150);
    run_phase(1, 1, 1, 120);
    run_phase(HIT_COUNT_RST, TIMEOUT_RST, 50, 170);

    // Register extremes. The send is long, so both sides run at full rate
    // and the lines always cooperate.
    apply_setting(255, 65535, 1);
    force_quiet = 1'b1;
    drive_send(7'($urandom), 100);
    drive_reset();
    force_quiet = 1'b0;

    // Wait out the last results, with a bound, before the final check.
    in_ch.valid <= 1'b0;
    for (int n = 0; n < 200 && sb.line_picture_q.size() != 0; n++) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    if (sb.line_picture_q.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.line_picture_q.size()));
    end
    if (sb.err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lpt_pkg.sv
rtl/lpt_in_if.sv
rtl/lpt_out_if.sv
rtl/lpt_cfg_regs.sv
rtl/lpt_fsm.sv
rtl/lpt_out_stage.sv
rtl/lpt_printer_handshake_core.sv
bench/tb_top.sv
